### sv/fwrc_pkg.sv
// Package for the fetch window refill controller: field widths and word codes.
`default_nettype none
package fwrc_pkg;

   // Field widths
   localparam int ADDR_W = 64;
   localparam int SIZE_W = 17;
   localparam int OFF_W  = 16;

   // Packed word widths (padded to whole bytes)
   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 104;

   // Substitute refill size when chunk_size is zero
   localparam logic [SIZE_W-1:0] DEFAULT_CHUNK = 17'd4096;

   // Result kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_HIT  = 2'd0;
   localparam kind_type KIND_READ = 2'd1;
   localparam kind_type KIND_FAIL = 2'd2;
   localparam kind_type KIND_BAD  = 2'd3;

   // Input operations
   typedef logic op_type;
   localparam op_type OP_ACCESS = 1'b0;
   localparam op_type OP_DONE   = 1'b1;

   // Register indexes
   localparam logic REG_CHUNK_SIZE = 1'b0;

endpackage
`default_nettype wire

### sv/fetch_window_refill_controller.sv
// Top level of the fetch window refill controller.
//
// Tracks one buffered window over memory and answers each request word with a hit
// offset, a read command, or a failure; completion words report whether the last read
// command worked and drive halving and retry. The block takes one word per cycle while
// the result stream is not stalled, and returns exactly one result word per input word.
// A word goes from the input register through the decision logic into the result
// register. A stalled result word holds the input register and so holds off new words.
// State updates land in the same cycle the result is registered, so back-to-back words
// see each other's effects. chunk_size is written over the APB port at byte address 0,
// and takes effect for the next miss.
`default_nettype none
module fetch_window_refill_controller #(
   parameter int MAX_WINDOW = 65536
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [63:0] address, [80:64] need_bytes, [81] read_ok, zero pad above
   input  wire logic [fwrc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] operation
   input  wire logic                            req_tuser,
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [63:0] read_base, [80:64] read_size, [96:81] window_offset, zero pad above
   output logic [fwrc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] kind
   output logic [1:0]                           rsp_tuser,
   // configuration port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [2:0]                      csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   localparam int AW    = fwrc_pkg::ADDR_W;
   localparam int SW    = fwrc_pkg::SIZE_W;
   localparam int OW    = fwrc_pkg::OFF_W;
   localparam int MW_W  = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W = ((MW_W > SW) ? MW_W : SW) + 1;
   localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_WINDOW);

   // configuration register
   logic [SW-1:0] chunk_ff, chunk_in;
   logic          csr_wr;

   // input register
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_op_ff, s1_op_in;
   logic [AW-1:0] s1_addr_ff, s1_addr_in;
   logic [SW-1:0] s1_need_ff, s1_need_in;
   logic          s1_ok_ff, s1_ok_in;

   // window and refill state
   logic [AW-1:0] win_start_ff, win_start_in;
   logic [SW-1:0] win_len_ff, win_len_in;
   logic          busy_ff, busy_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [SW-1:0] pend_need_ff, pend_need_in;
   logic [AW-1:0] try_base_ff, try_base_in;
   logic [SW-1:0] try_size_ff, try_size_in;
   logic [SW-1:0] target_ff, target_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   fwrc_pkg::kind_type   rsp_kind_ff, rsp_kind_in;
   logic [AW-1:0]        rsp_base_ff, rsp_base_in;
   logic [SW-1:0]        rsp_size_ff, rsp_size_in;
   logic [OW-1:0]        rsp_off_ff, rsp_off_in;

   // handshake
   logic out_free, s2_go, req_fire;

   // decision terms
   logic [AW-1:0]    win_diff;
   logic             addr_ge;
   logic             hit;
   logic             backward;
   logic [SW-1:0]    chunk_eff;
   logic [SW-1:0]    want;
   logic [SW-1:0]    behind;
   logic [AW-1:0]    miss_base;
   logic             need_bad;
   logic [SW:0]      least;
   logic [SW-1:0]    half;
   logic [SW-1:0]    shrunk;
   logic [AW-1:0]    pend_diff;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s2_go      = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   // APB access: always ready, write lands in the access phase
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == fwrc_pkg::REG_CHUNK_SIZE) ?
                       {{(32-SW){1'b0}}, chunk_ff} : 32'd0;

   always_comb begin
      chunk_in = chunk_ff;
      if (csr_wr && csr_paddr[2] == fwrc_pkg::REG_CHUNK_SIZE) begin
         chunk_in = csr_pwdata[SW-1:0];
      end
   end

   // input register load
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s2_go) begin
         s1_valid_in = 1'b0;
      end
      s1_op_in   = req_fire ? req_tuser           : s1_op_ff;
      s1_addr_in = req_fire ? req_tdata[63:0]     : s1_addr_ff;
      s1_need_in = req_fire ? req_tdata[80:64]    : s1_need_ff;
      s1_ok_in   = req_fire ? req_tdata[81]       : s1_ok_ff;
   end

   // window hit test and miss command terms
   assign win_diff = s1_addr_ff - win_start_ff;
   assign addr_ge  = s1_addr_ff >= win_start_ff;
   assign hit      = (win_len_ff != '0) && addr_ge && (s1_need_ff <= win_len_ff) &&
                     (win_diff[AW-1:SW] == '0) &&
                     (win_diff[SW-1:0] <= (win_len_ff - s1_need_ff));
   assign backward = (win_len_ff != '0) && !addr_ge;
   assign need_bad = (s1_need_ff == '0) ||
                     ({{(CMP_W-SW){1'b0}}, s1_need_ff} > MAX_CMP);

   always_comb begin
      chunk_eff = (chunk_ff == '0) ? fwrc_pkg::DEFAULT_CHUNK : chunk_ff;
      if ({{(CMP_W-SW){1'b0}}, chunk_eff} > MAX_CMP) begin
         chunk_eff = SW'(MAX_WINDOW);
      end
   end

   assign want      = (chunk_eff > s1_need_ff) ? chunk_eff : s1_need_ff;
   assign behind    = backward ? (want - s1_need_ff) : '0;
   assign miss_base = (s1_addr_ff >= {{(AW-SW){1'b0}}, behind}) ?
                      (s1_addr_ff - {{(AW-SW){1'b0}}, behind}) : '0;

   // failed read: shrink toward the least size covering the request
   assign pend_diff = pend_addr_ff - try_base_ff;
   assign least     = {1'b0, pend_diff[SW-1:0]} + {1'b0, pend_need_ff};
   assign half      = try_size_ff >> 1;
   assign shrunk    = ({1'b0, half} > least) ? half : least[SW-1:0];

   // decision and state update
   always_comb begin
      win_start_in = win_start_ff;
      win_len_in   = win_len_ff;
      busy_in      = busy_ff;
      pend_addr_in = pend_addr_ff;
      pend_need_in = pend_need_ff;
      try_base_in  = try_base_ff;
      try_size_in  = try_size_ff;
      target_in    = target_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_off_in   = rsp_off_ff;
      if (s2_go) begin
         rsp_base_in = '0;
         rsp_size_in = '0;
         rsp_off_in  = '0;
         if (s1_op_ff == fwrc_pkg::OP_ACCESS) begin
            if (busy_ff) begin
               rsp_kind_in = fwrc_pkg::KIND_BAD;
            end else if (need_bad) begin
               rsp_kind_in = fwrc_pkg::KIND_FAIL;
            end else if (hit) begin
               rsp_kind_in = fwrc_pkg::KIND_HIT;
               rsp_off_in  = win_diff[OW-1:0];
            end else begin
               // miss: empty the window and issue the refill read
               win_len_in   = '0;
               pend_addr_in = s1_addr_ff;
               pend_need_in = s1_need_ff;
               target_in    = want;
               try_base_in  = miss_base;
               try_size_in  = want;
               busy_in      = 1'b1;
               rsp_kind_in  = fwrc_pkg::KIND_READ;
               rsp_base_in  = miss_base;
               rsp_size_in  = want;
            end
         end else if (!busy_ff) begin
            rsp_kind_in = fwrc_pkg::KIND_BAD;
         end else if (s1_ok_ff) begin
            // read worked: record the window, answer the request
            win_start_in = try_base_ff;
            win_len_in   = try_size_ff;
            busy_in      = 1'b0;
            rsp_kind_in  = fwrc_pkg::KIND_HIT;
            rsp_off_in   = pend_diff[OW-1:0];
         end else if ({1'b0, try_size_ff} > least) begin
            try_size_in = shrunk;
            rsp_kind_in = fwrc_pkg::KIND_READ;
            rsp_base_in = try_base_ff;
            rsp_size_in = shrunk;
         end else if (try_base_ff != pend_addr_ff) begin
            // last chance: full size straight from the address
            try_base_in = pend_addr_ff;
            try_size_in = target_ff;
            rsp_kind_in = fwrc_pkg::KIND_READ;
            rsp_base_in = pend_addr_ff;
            rsp_size_in = target_ff;
         end else begin
            busy_in     = 1'b0;
            rsp_kind_in = fwrc_pkg::KIND_FAIL;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff     <= fwrc_pkg::DEFAULT_CHUNK;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         win_len_ff   <= '0;
         busy_ff      <= 1'b0;
      end else begin
         chunk_ff     <= chunk_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         win_len_ff   <= win_len_in;
         busy_ff      <= busy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_addr_ff   <= s1_addr_in;
      s1_need_ff   <= s1_need_in;
      s1_ok_ff     <= s1_ok_in;
      win_start_ff <= win_start_in;
      pend_addr_ff <= pend_addr_in;
      pend_need_ff <= pend_need_in;
      try_base_ff  <= try_base_in;
      try_size_ff  <= try_size_in;
      target_ff    <= target_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_off_ff   <= rsp_off_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{(fwrc_pkg::RSP_DATA_W-AW-SW-OW){1'b0}},
                        rsp_off_ff, rsp_size_ff, rsp_base_ff};

endmodule
`default_nettype wire

### sv/fwrc_checker.sv
// Port-level checker for the fetch window refill controller, with its bind.
`default_nettype none
module fwrc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [103:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // no result word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word valid after reset");

   // read fields are zero unless the word is a read command
   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != fwrc_pkg::KIND_READ |-> rsp_tdata[80:0] == '0)
      else $error("read fields set on non-read word");

   // a read command never asks for zero bytes
   a_read_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == fwrc_pkg::KIND_READ |->
         rsp_tdata[80:64] != '0 && rsp_tdata[96:81] == '0)
      else $error("bad read command");

   // offset only on an answer
   a_offset: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != fwrc_pkg::KIND_HIT |-> rsp_tdata[96:81] == '0)
      else $error("offset set on non-answer word");

endmodule

bind fetch_window_refill_controller fwrc_checker u_fwrc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

### bench/fetch_window_refill_controller_tb.sv
// Self-checking testbench for the fetch window refill controller: directed table, then random.
`timescale 1ns / 100ps
module fetch_window_refill_controller_tb;

   localparam int MAX_WINDOW = 65536;
   localparam logic [2:0] CHUNK_ADDR = {fwrc_pkg::REG_CHUNK_SIZE, 2'b00};
   localparam int PHASES = 6;
   localparam int PHASE_WORDS = 67;

   // one result word, unpacked from the rsp bus
   typedef struct packed {
      fwrc_pkg::kind_type kind;
      logic [63:0]        base;
      logic [16:0]        size;
      logic [15:0]        off;
   } rsp_word_type;

   // directed table row: either a chunk_size write or one request/completion word
   typedef struct {
      logic             is_cfg;
      logic [16:0]      cfg_value;
      fwrc_pkg::op_type op;
      logic [63:0]      addr;
      logic [16:0]      need;
      logic             ok;
      logic             typed;
      rsp_word_type     rsp;
   } dir_row_type;

   typedef enum {RDY_OPEN, RDY_RANDOM, RDY_SPARSE} ready_mode_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [fwrc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic                            req_tuser = fwrc_pkg::OP_ACCESS;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [fwrc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                      rsp_tuser;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [2:0]                      csr_paddr = '0;
   logic [31:0]                     csr_pwdata = '0;
   logic [31:0]                     csr_prdata;
   logic                            csr_pready;

   // predicted block state
   logic [16:0] fw_chunk;
   logic [63:0] fw_start;
   logic [16:0] fw_len;
   logic        fw_busy;
   logic [63:0] fw_pend_addr;
   logic [16:0] fw_pend_need;
   logic [63:0] fw_try_base;
   logic [16:0] fw_try_size;
   logic [16:0] fw_target;

   rsp_word_type   expected_rsp[$];
   dir_row_type    dir_rows[$];
   logic           use_typed = 1'b0;
   rsp_word_type   typed_rsp = '0;
   int             mismatch_count = 0;
   ready_mode_type ready_mode = RDY_OPEN;
   int             ready_left = 0;
   int             ready_phase = 0;

   fetch_window_refill_controller #(.MAX_WINDOW(MAX_WINDOW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("fetch_window_refill_controller_tb: errors");
      $finish;
   end

   // Next result of the window controller for one accepted word; updates the state.
   function automatic rsp_word_type predict_refill(input fwrc_pkg::op_type op,
                                                   input logic [63:0] addr,
                                                   input logic [16:0] need, input logic ok);
      rsp_word_type r;
      logic [16:0]  chunk;
      logic [16:0]  want;
      logic [16:0]  half;
      logic [63:0]  behind;
      logic [63:0]  least;
      logic         backward;
      r = '0;
      r.kind = fwrc_pkg::KIND_BAD;
      if (op == fwrc_pkg::OP_ACCESS) begin
         if (fw_busy) begin
            r.kind = fwrc_pkg::KIND_BAD;
         end else if (need == 0 || need > MAX_WINDOW) begin
            r.kind = fwrc_pkg::KIND_FAIL;
         end else if (fw_len != 0 && addr >= fw_start && need <= fw_len &&
                      addr - fw_start <= 64'(fw_len - need)) begin
            r.kind = fwrc_pkg::KIND_HIT;
            r.off  = 16'(addr - fw_start);
         end else begin
            backward = fw_len != 0 && addr < fw_start;
            fw_len = '0;
            chunk = (fw_chunk == 0) ? fwrc_pkg::DEFAULT_CHUNK : fw_chunk;
            if (chunk > MAX_WINDOW)
               chunk = 17'(MAX_WINDOW);
            want = (chunk > need) ? chunk : need;
            behind = backward ? 64'(want - need) : 64'd0;
            fw_pend_addr = addr;
            fw_pend_need = need;
            fw_target    = want;
            fw_try_base  = (addr >= behind) ? addr - behind : 64'd0;
            fw_try_size  = want;
            fw_busy      = 1'b1;
            r.kind = fwrc_pkg::KIND_READ;
            r.base = fw_try_base;
            r.size = fw_try_size;
         end
      end else if (!fw_busy) begin
         r.kind = fwrc_pkg::KIND_BAD;
      end else if (ok) begin
         fw_start = fw_try_base;
         fw_len   = fw_try_size;
         fw_busy  = 1'b0;
         r.kind = fwrc_pkg::KIND_HIT;
         r.off  = 16'(fw_pend_addr - fw_try_base);
      end else begin
         // failed read: halve toward the least covering size, then retry from the address
         least = (fw_pend_addr - fw_try_base) + 64'(fw_pend_need);
         if (64'(fw_try_size) > least) begin
            half = fw_try_size >> 1;
            fw_try_size = (64'(half) > least) ? half : least[16:0];
            r.kind = fwrc_pkg::KIND_READ;
            r.base = fw_try_base;
            r.size = fw_try_size;
         end else if (fw_try_base != fw_pend_addr) begin
            fw_try_base = fw_pend_addr;
            fw_try_size = fw_target;
            r.kind = fwrc_pkg::KIND_READ;
            r.base = fw_try_base;
            r.size = fw_try_size;
         end else begin
            fw_busy = 1'b0;
            r.kind = fwrc_pkg::KIND_FAIL;
         end
      end
      return r;
   endfunction

   // Predict on accepted words, check result words, track chunk_size writes.
   always @(posedge clock) begin : watch
      rsp_word_type got;
      rsp_word_type want;
      rsp_word_type model;
      if (reset) begin
         fw_chunk = fwrc_pkg::DEFAULT_CHUNK;
         fw_start = '0;
         fw_len = '0;
         fw_busy = 1'b0;
         fw_pend_addr = '0;
         fw_pend_need = '0;
         fw_try_base = '0;
         fw_try_size = '0;
         fw_target = '0;
         expected_rsp.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            model = predict_refill(req_tuser, req_tdata[63:0], req_tdata[80:64],
                                   req_tdata[81]);
            expected_rsp.push_back(use_typed ? typed_rsp : model);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.base = rsp_tdata[63:0];
            got.size = rsp_tdata[80:64];
            got.off  = rsp_tdata[96:81];
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result word with nothing expected: %s %0d base %h %s %0d %s %0d",
                           $realtime, "kind", got.kind, got.base, "size", got.size, "off",
                           got.off);
            end else begin
               want = expected_rsp.pop_front();
               if (got.kind !== want.kind || got.base !== want.base ||
                   got.size !== want.size || got.off !== want.off) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: mismatch exp/act kind %0d/%0d base %h/%h %s %0d/%0d %s",
                              $realtime, want.kind, got.kind, want.base, got.base,
                              "size", want.size, got.size,
                              $sformatf("off %0d/%0d", want.off, got.off));
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == CHUNK_ADDR)
            fw_chunk = csr_pwdata[16:0];
      end
   end

   // Result-side backpressure: open, random or sparse ready modes, picked at random.
   always @(negedge clock) begin
      if (ready_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_left = $urandom_range(16, 96);
      end
      ready_left--;
      ready_phase++;
      case (ready_mode)
         RDY_OPEN:   rsp_tready <= 1'b1;
         RDY_RANDOM: rsp_tready <= ($urandom_range(0, 99) < 70);
         default:    rsp_tready <= (ready_phase % 4 == 0);
      endcase
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_word(input fwrc_pkg::op_type op, input logic [63:0] addr,
                            input logic [16:0] need, input logic ok);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= fwrc_pkg::REQ_DATA_W'({ok, need, addr});
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_rsp.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // APB write of chunk_size, then read it back.
   task automatic write_chunk(input logic [16:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CHUNK_ADDR;
      csr_pwdata  <= 32'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[16:0] !== value) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: chunk_size readback exp %0d act %0d", $realtime, value,
                     csr_prdata[16:0]);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic add_item(input fwrc_pkg::op_type op, input logic [63:0] addr,
                           input logic [16:0] need, input logic ok);
      dir_row_type row;
      row = '{is_cfg: 1'b0, cfg_value: '0, op: op, addr: addr, need: need, ok: ok,
              typed: 1'b0, rsp: '0};
      dir_rows.push_back(row);
   endtask

   task automatic add_typed(input fwrc_pkg::op_type op, input logic [63:0] addr,
                            input logic [16:0] need, input logic ok,
                            input fwrc_pkg::kind_type kind, input logic [63:0] base,
                            input logic [16:0] size);
      dir_row_type row;
      row = '{is_cfg: 1'b0, cfg_value: '0, op: op, addr: addr, need: need, ok: ok,
              typed: 1'b1, rsp: '0};
      row.rsp.kind = kind;
      row.rsp.base = base;
      row.rsp.size = size;
      dir_rows.push_back(row);
   endtask

   task automatic add_chunk(input logic [16:0] value);
      dir_row_type row;
      row = '{is_cfg: 1'b1, cfg_value: value, op: fwrc_pkg::OP_ACCESS, addr: '0, need: '0,
              ok: 1'b0, typed: 1'b0, rsp: '0};
      dir_rows.push_back(row);
   endtask

   initial begin
      logic [16:0]      phase_chunk[PHASES];
      fwrc_pkg::op_type op;
      logic [63:0]      addr;
      logic [16:0]      need;
      logic             ok;
      logic             counted;
      logic             idle_on;
      int               sent;
      int               burst_left;
      int unsigned      pick;
      int unsigned      nsel;

      // directed table
      add_typed(fwrc_pkg::OP_ACCESS, 64'h1000, 17'd16, 1'b0, fwrc_pkg::KIND_READ,
                64'h1000, 17'd4096);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b1);
      add_item (fwrc_pkg::OP_ACCESS, 64'h1F00, 17'd256, 1'b0);   // hit ending on window end
      add_item (fwrc_pkg::OP_ACCESS, 64'h0800, 17'd256, 1'b0);   // below window, base at zero
      add_typed(fwrc_pkg::OP_ACCESS, 64'h1234, 17'd8, 1'b1, fwrc_pkg::KIND_BAD,
                64'h0, 17'd0);
      add_chunk(17'd1);                                          // chunk change mid refill
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b0);        // retry from the address
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b0);        // unreadable
      add_typed(fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b1, fwrc_pkg::KIND_BAD,
                64'h0, 17'd0);
      add_typed(fwrc_pkg::OP_ACCESS, 64'h40, 17'd0, 1'b0, fwrc_pkg::KIND_FAIL,
                64'h0, 17'd0);
      add_typed(fwrc_pkg::OP_ACCESS, 64'h40, 17'h1FFFF, 1'b1, fwrc_pkg::KIND_FAIL,
                64'h0, 17'd0);
      add_typed(fwrc_pkg::OP_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 17'd65536, 1'b0,
                fwrc_pkg::KIND_READ, 64'hFFFF_FFFF_FFFF_FFFF, 17'd65536);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b1);
      add_item (fwrc_pkg::OP_ACCESS, 64'hFFFF_FFFF_FFFF_FFFF, 17'd1, 1'b0);
      add_item (fwrc_pkg::OP_ACCESS, 64'hFFFF_FFFF_FFFF_0000, 17'd1, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b1);
      add_chunk(17'd0);                                          // zero chunk acts as default
      add_item (fwrc_pkg::OP_ACCESS, 64'h0, 17'd1, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b1);
      add_chunk(17'h1FFFF);                                      // oversized chunk is capped
      add_item (fwrc_pkg::OP_ACCESS, 64'h10000, 17'd1, 1'b0);
      add_item (fwrc_pkg::OP_DONE,   64'h0, 17'd0, 1'b1);
      add_item (fwrc_pkg::OP_ACCESS, 64'h1FFFF, 17'd1, 1'b0);    // largest offset

      phase_chunk[0] = 17'($urandom_range(2, 4096));
      phase_chunk[1] = 17'd65536;
      phase_chunk[2] = 17'd16;
      phase_chunk[3] = 17'd0;
      phase_chunk[4] = 17'h1FFFF;
      phase_chunk[5] = 17'd1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            drain_results();
            write_chunk(dir_rows[i].cfg_value);
         end else begin
            use_typed = dir_rows[i].typed;
            typed_rsp = dir_rows[i].rsp;
            send_word(dir_rows[i].op, dir_rows[i].addr, dir_rows[i].need, dir_rows[i].ok);
         end
      end
      use_typed = 1'b0;

      // random phases, one chunk setting each
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         write_chunk(phase_chunk[phase]);
         idle_on = (phase % 3 != 2);
         burst_left = 0;
         sent = 0;
         while (sent < PHASE_WORDS) begin
            if ($urandom_range(0, 59) == 0)
               drain_results();
            if (burst_left == 0) begin
               if (idle_on) begin
                  req_tvalid <= 1'b0;
                  repeat ($urandom_range(1, 6)) @(negedge clock);
               end
               burst_left = $urandom_range(1, 24);
            end
            burst_left--;

            ok = $urandom_range(0, 1);
            addr = {$urandom, $urandom};
            need = 17'($urandom_range(1, 64));
            if (fw_busy) begin
               if ($urandom_range(0, 99) < 90) begin
                  op = fwrc_pkg::OP_DONE;
                  ok = ($urandom_range(0, 99) < 40);
                  counted = 1'b1;
               end else begin
                  op = fwrc_pkg::OP_ACCESS;
                  counted = 1'b0;
               end
            end else if ($urandom_range(0, 99) < 4) begin
               op = fwrc_pkg::OP_DONE;
               counted = 1'b0;
            end else begin
               op = fwrc_pkg::OP_ACCESS;
               counted = 1'b1;
               nsel = $urandom_range(0, 19);
               if (nsel >= 19)
                  need = '0;
               else if (nsel >= 17)
                  need = 17'($urandom);
               else if (nsel >= 12)
                  need = 17'($urandom_range(1, MAX_WINDOW));
               pick = $urandom_range(0, 19);
               if (fw_len != 0 && pick < 9)
                  addr = fw_start + 64'($urandom_range(0, fw_len - 1));
               else if (fw_len != 0 && pick < 13)
                  addr = fw_start - 64'($urandom_range(1, 3 * MAX_WINDOW));
               else if (fw_len != 0 && pick < 16)
                  addr = fw_start + 64'(fw_len) + 64'($urandom_range(0, 4096));
               else begin
                  case ($urandom_range(0, 2))
                     0:       addr = 64'($urandom_range(0, 1 << 18));
                     1:       addr = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1 << 18));
                     default: addr = {$urandom, $urandom};
                  endcase
               end
            end
            send_word(op, addr, need, ok);
            if (counted)
               sent++;
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp.size() == 0)
         $display("fetch_window_refill_controller_tb: clean");
      else
         $display("fetch_window_refill_controller_tb: errors");
      $finish;
   end

endmodule

### fetch_window_refill_controller.f
sv/fwrc_pkg.sv
sv/fetch_window_refill_controller.sv
sv/fwrc_checker.sv
bench/fetch_window_refill_controller_tb.sv
